// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");

`endif

// File: src/bamap_pkg.sv
// ----------------------------------------------------------------------------
// bamap_pkg
// Types, constants and symbol selection for the block-average mapper.
// ----------------------------------------------------------------------------
package bamap_pkg;

   localparam int unsigned SUM_W       = 20;
   localparam int unsigned BAND_DEPTH  = 512;
   localparam int unsigned BAND_AW     = 9;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = 2;
   localparam int unsigned CSR_IDX_W   = 3;

   localparam logic [10:0] DIM_MAX   = 11'd1024;
   localparam logic [6:0]  TILE_MIN  = 7'd2;
   localparam logic [6:0]  TILE_MAX  = 7'd64;
   localparam logic [3:0]  SYM_MAX   = 4'd8;
   localparam logic [3:0]  SYM_DFLT  = 4'd7;
   localparam logic [7:0]  NEWLINE   = 8'd10;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_EDGE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOL_COUNT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOL_TABLE = 3'd4;

   localparam logic [10:0] RST_FRAME_WIDTH  = 11'd640;
   localparam logic [10:0] RST_FRAME_HEIGHT = 11'd480;
   localparam logic [6:0]  RST_TILE_EDGE    = 7'd2;
   localparam logic [3:0]  RST_SYMBOL_COUNT = 4'd7;
   localparam logic [63:0] RST_SYMBOL_TABLE = 64'h0040_4F6F_7E2D_2E20;

   typedef struct packed {
      logic [10:0] width;
      logic [10:0] height;
      logic [6:0]  tile;
   } geom_type;

   typedef struct packed {
      logic             is_nl;
      logic [SUM_W-1:0] sum;
      logic             run_last;
      logic             frame_last;
   } item_type;

   typedef struct packed {
      logic add_band;
      logic add_tail;
      logic also_b;
      logic emit_band;
      logic emit_tail;
      logic newline;
      logic nl_last;
   } pix_flags_type;

   function automatic logic [7:0] step_of(input logic [3:0] cnt);
      logic [7:0] st;
      unique case (cnt)
         4'd2:    st = 8'd127;
         4'd3:    st = 8'd85;
         4'd4:    st = 8'd63;
         4'd5:    st = 8'd51;
         4'd6:    st = 8'd42;
         4'd7:    st = 8'd36;
         4'd8:    st = 8'd31;
         default: st = 8'd255;
      endcase
      return st;
   endfunction

   function automatic logic [7:0] default_sym(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0:    c = 8'd32;
         3'd1:    c = 8'd46;
         3'd2:    c = 8'd45;
         3'd3:    c = 8'd126;
         3'd4:    c = 8'd111;
         3'd5:    c = 8'd79;
         default: c = 8'd64;
      endcase
      return c;
   endfunction

   // First index whose band [(i-1)*step, (i+1)*step] holds the mean, else the last.
   function automatic logic [7:0] pick_symbol(input logic [7:0] mean,
                                              input logic [3:0] count,
                                              input logic [63:0] symbols);
      logic        dflt;
      logic [3:0]  cnt;
      logic [7:0]  st;
      logic [11:0] lo;
      logic [11:0] hi;
      logic [2:0]  sel;
      logic        found;
      dflt  = (count == 4'd0);
      cnt   = dflt ? SYM_DFLT : ((count > SYM_MAX) ? SYM_MAX : count);
      st    = step_of(cnt);
      sel   = 3'(cnt - 4'd1);
      found = 1'b0;
      for (int i = 0; i < 8; i++) begin
         lo = (i == 0) ? 12'd0 : 12'((i - 1) * st);
         hi = 12'((i + 1) * st);
         if (!found && (i < cnt) && ({4'd0, mean} >= lo) && ({4'd0, mean} <= hi)) begin
            found = 1'b1;
            sel   = 3'(i);
         end
      end
      return dflt ? default_sym(sel) : symbols[8*sel +: 8];
   endfunction

endpackage

// File: src/block_average_ascii_mapper_top.sv
// ----------------------------------------------------------------------------
// block_average_ascii_mapper_top
// Pixel stream in, one character per averaged tile plus row newlines out.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive req_red/green/blue with push; a pixel transfers on an
//   edge with push high and full low. Pixels arrive in raster order.
//   Result queue: while empty is low the oldest result is on rsp_symbol,
//   rsp_run_last and rsp_frame_last; pop high transfers it.
//   Config: csr_we with csr_index/csr_wdata writes a register.
//   Front throughput: one pixel per cycle for frames smaller than a tile;
//   otherwise each pixel takes a read-modify-write of the band-sum memory
//   port (RD_A, WR_A), one more pass (RD_B, WR_B) for the overlapping last
//   column or an NL state for a newline, with full high until idle again.
//   The back takes each tile through the 8-step serial divider before it
//   takes the next; the four-entry queue between them absorbs bursts.
//   Reset, and any write of frame_width, frame_height or tile_edge, start a
//   clearing pass over every entry of the sum memories with full held high.
//   A stalled receiver holds the result register; the back then stops and
//   the queue fills until full rises.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module block_average_ascii_mapper_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  logic [7:0]                        req_red,
   input  logic [7:0]                        req_green,
   input  logic [7:0]                        req_blue,
   output logic                              empty,
   input  logic                              pop,
   output logic [7:0]                        rsp_symbol,
   output logic                              rsp_run_last,
   output logic                              rsp_frame_last,
   input  logic                              csr_we,
   input  logic [bamap_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [63:0]                       csr_wdata
);
   logic [10:0] frame_width_ff, frame_width_in;
   logic [10:0] frame_height_ff, frame_height_in;
   logic [6:0]  tile_edge_ff, tile_edge_in;
   logic [3:0]  symbol_count_ff, symbol_count_in;
   logic [63:0] symbol_table_ff, symbol_table_in;
   logic [12:0] area_ff, area_in;

   bamap_pkg::geom_type geom;
   bamap_pkg::item_type q_wdata, q_rdata;
   logic                restart, q_push, q_pop, q_nonempty;
   logic [bamap_pkg::QUEUE_AW:0] q_count;
   logic                fl_seen;

   // Hold registers unless written.
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      tile_edge_in    = tile_edge_ff;
      symbol_count_in = symbol_count_ff;
      symbol_table_in = symbol_table_ff;
      restart         = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            bamap_pkg::CSR_FRAME_WIDTH: begin
               frame_width_in = csr_wdata[10:0];
               restart        = 1'b1;
            end
            bamap_pkg::CSR_FRAME_HEIGHT: begin
               frame_height_in = csr_wdata[10:0];
               restart         = 1'b1;
            end
            bamap_pkg::CSR_TILE_EDGE: begin
               tile_edge_in = csr_wdata[6:0];
               restart      = 1'b1;
            end
            bamap_pkg::CSR_SYMBOL_COUNT: symbol_count_in = csr_wdata[3:0];
            bamap_pkg::CSR_SYMBOL_TABLE: symbol_table_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Clamp geometry into its legal range.
   always_comb begin
      geom.width  = (frame_width_ff == 11'd0) ? 11'd1 :
                    (frame_width_ff > bamap_pkg::DIM_MAX) ? bamap_pkg::DIM_MAX :
                    frame_width_ff;
      geom.height = (frame_height_ff == 11'd0) ? 11'd1 :
                    (frame_height_ff > bamap_pkg::DIM_MAX) ? bamap_pkg::DIM_MAX :
                    frame_height_ff;
      geom.tile   = (tile_edge_ff < bamap_pkg::TILE_MIN) ? bamap_pkg::TILE_MIN :
                    (tile_edge_ff > bamap_pkg::TILE_MAX) ? bamap_pkg::TILE_MAX :
                    tile_edge_ff;
      area_in     = 13'(geom.tile) * 13'(geom.tile);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= bamap_pkg::RST_FRAME_WIDTH;
         frame_height_ff <= bamap_pkg::RST_FRAME_HEIGHT;
         tile_edge_ff    <= bamap_pkg::RST_TILE_EDGE;
         symbol_count_ff <= bamap_pkg::RST_SYMBOL_COUNT;
         symbol_table_ff <= bamap_pkg::RST_SYMBOL_TABLE;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         tile_edge_ff    <= tile_edge_in;
         symbol_count_ff <= symbol_count_in;
         symbol_table_ff <= symbol_table_in;
      end
   end

   // Area is stable long before the first tile reaches the divider.
   always_ff @(posedge clock) begin
      area_ff <= area_in;
   end

   bamap_front u_front (
      .clock   (clock),
      .reset   (reset),
      .restart (restart),
      .geom    (geom),
      .push    (push),
      .red     (req_red),
      .green   (req_green),
      .blue    (req_blue),
      .full    (full),
      .q_count (q_count),
      .q_push  (q_push),
      .q_data  (q_wdata)
   );

   bamap_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_push),
      .wr_data  (q_wdata),
      .rd_en    (q_pop),
      .rd_data  (q_rdata),
      .nonempty (q_nonempty),
      .count    (q_count)
   );

   bamap_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_nonempty   (q_nonempty),
      .q_data       (q_rdata),
      .q_pop        (q_pop),
      .area         (area_ff),
      .symbol_count (symbol_count_ff),
      .symbol_table (symbol_table_ff),
      .empty        (empty),
      .pop          (pop),
      .symbol       (rsp_symbol),
      .run_last     (rsp_run_last),
      .frame_last   (rsp_frame_last)
   );

   assign fl_seen = !empty && rsp_frame_last;

   // Geometry writes restart the frame: intake must close on the next cycle.
   `ASSERT_NEXT(a_restart_blocks, clock, reset, restart, full)
   // Frame end marker only ever rides on a newline.
   `ASSERT_IMPLIES(a_frame_last_nl, clock, reset, fl_seen, rsp_symbol == bamap_pkg::NEWLINE)
   // Frame end newline is always the last result of its pixel.
   `ASSERT_IMPLIES(a_frame_last_run, clock, reset, fl_seen, rsp_run_last)
endmodule

// File: src/bamap_fifo.sv
// ----------------------------------------------------------------------------
// bamap_fifo
// Short queue of tile and newline work between front and back.
// ----------------------------------------------------------------------------
module bamap_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  bamap_pkg::item_type           wr_data,
   input  logic                          rd_en,
   output bamap_pkg::item_type           rd_data,
   output logic                          nonempty,
   output logic [bamap_pkg::QUEUE_AW:0]  count
);
   bamap_pkg::item_type slot_ff [bamap_pkg::QUEUE_DEPTH];
   logic [bamap_pkg::QUEUE_AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [bamap_pkg::QUEUE_AW:0]   cnt_ff, cnt_in;

   always_comb begin
      wp_in  = wr_en ? wp_ff + 1'b1 : wp_ff;
      rp_in  = rd_en ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + {{bamap_pkg::QUEUE_AW{1'b0}}, wr_en}
                      - {{bamap_pkg::QUEUE_AW{1'b0}}, rd_en};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wp_ff] <= wr_data;
      end
   end

   assign rd_data  = slot_ff[rp_ff];
   assign nonempty = (cnt_ff != '0);
   assign count    = cnt_ff;
endmodule

// File: src/bamap_front.sv
// ----------------------------------------------------------------------------
// bamap_front
// Pixel intake, raster tracking and per-band tile sums in memory.
// ----------------------------------------------------------------------------
module bamap_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          restart,
   input  bamap_pkg::geom_type           geom,
   input  logic                          push,
   input  logic [7:0]                    red,
   input  logic [7:0]                    green,
   input  logic [7:0]                    blue,
   output logic                          full,
   input  logic [bamap_pkg::QUEUE_AW:0]  q_count,
   output logic                          q_push,
   output bamap_pkg::item_type           q_data
);
   typedef enum logic [7:0] {
      F_INIT  = 8'b0000_0001,
      F_CLEAR = 8'b0000_0010,
      F_IDLE  = 8'b0000_0100,
      F_RD_A  = 8'b0000_1000,
      F_WR_A  = 8'b0001_0000,
      F_RD_B  = 8'b0010_0000,
      F_WR_B  = 8'b0100_0000,
      F_NL    = 8'b1000_0000
   } front_state_type;

   localparam int unsigned AW = bamap_pkg::BAND_AW;
   localparam int unsigned SW = bamap_pkg::SUM_W;

   front_state_type state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in, lc_ff, lc_in, lr_ff, lr_in;
   logic [9:0]    wrem_ff, wrem_in, hrem_ff, hrem_in;
   logic [9:0]    x_ff, x_in, y_ff, y_in;
   logic [5:0]    xo_ff, xo_in, yo_ff, yo_in;
   logic [AW-1:0] a_ff, a_in, ty_ff, ty_in, pa_ff, pa_in;
   logic [7:0]    g_ff, g_in;
   bamap_pkg::pix_flags_type pf_ff, pf_in;

   logic [SW-1:0] band_sums_ff [bamap_pkg::BAND_DEPTH];
   logic [SW-1:0] tail_sums_ff [bamap_pkg::BAND_DEPTH];
   logic [SW-1:0] rd_band_ff, rd_tail_ff;

   logic          accept, ok, x_last, y_last, xo_end, yo_end;
   logic          in_band, in_tail, in_last_col, band_row_end, tail_row_end, done;
   logic [9:0]    sum3;
   logic [19:0]   prod;
   logic [9:0]    e_m1;
   logic          rd_en, band_we, tail_we;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [SW-1:0] band_wd, tail_wd, nb, nt;

   assign e_m1   = 10'(geom.tile) - 10'd1;
   assign ok     = (geom.width >= 11'(geom.tile)) && (geom.height >= 11'(geom.tile));
   assign full   = (state_ff != F_IDLE) ||
                   (q_count > (bamap_pkg::QUEUE_AW+1)'(bamap_pkg::QUEUE_DEPTH - 2));
   assign accept = push && !full;

   always_comb begin
      sum3         = 10'(red) + 10'(green) + 10'(blue);
      prod         = 20'(sum3) * 20'd683;
      x_last       = ({1'b0, x_ff} == geom.width - 11'd1);
      y_last       = ({1'b0, y_ff} == geom.height - 11'd1);
      xo_end       = (10'(xo_ff) == e_m1);
      yo_end       = (10'(yo_ff) == e_m1);
      in_last_col  = (12'(x_ff) + 12'(geom.tile)) >= 12'(geom.width);
      in_tail      = (12'(y_ff) + 12'(geom.tile)) >= 12'(geom.height);
      in_band      = (ty_ff < lr_ff);
      band_row_end = in_band && yo_end;
      tail_row_end = y_last;
      done         = x_last || (xo_end && (a_ff < lc_ff));
      nb           = rd_band_ff + SW'(g_ff);
      nt           = rd_tail_ff + SW'(g_ff);
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      lc_in    = lc_ff;
      lr_in    = lr_ff;
      wrem_in  = wrem_ff;
      hrem_in  = hrem_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      xo_in    = xo_ff;
      yo_in    = yo_ff;
      a_in     = a_ff;
      ty_in    = ty_ff;
      pa_in    = pa_ff;
      g_in     = g_ff;
      pf_in    = pf_ff;
      rd_en    = 1'b0;
      rd_addr  = pa_ff;
      band_we  = 1'b0;
      tail_we  = 1'b0;
      wr_addr  = pa_ff;
      band_wd  = nb;
      tail_wd  = nt;
      q_push   = 1'b0;
      q_data   = '{is_nl: 1'b0, sum: '0, run_last: 1'b1, frame_last: 1'b0};

      unique case (state_ff)
         F_INIT: begin
            clr_in   = '0;
            lc_in    = '0;
            lr_in    = '0;
            wrem_in  = 10'(geom.width - 11'd1);
            hrem_in  = 10'(geom.height - 11'd1);
            x_in     = '0;
            y_in     = '0;
            xo_in    = '0;
            yo_in    = '0;
            a_in     = '0;
            ty_in    = '0;
            state_in = F_CLEAR;
         end
         F_CLEAR: begin
            // zero one entry a cycle; derive last tile column and row meanwhile
            band_we = 1'b1;
            tail_we = 1'b1;
            wr_addr = clr_ff;
            band_wd = '0;
            tail_wd = '0;
            if (wrem_ff >= 10'(geom.tile)) begin
               wrem_in = wrem_ff - 10'(geom.tile);
               lc_in   = lc_ff + 1'b1;
            end
            if (hrem_ff >= 10'(geom.tile)) begin
               hrem_in = hrem_ff - 10'(geom.tile);
               lr_in   = lr_ff + 1'b1;
            end
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(bamap_pkg::BAND_DEPTH - 1)) begin
               state_in = F_IDLE;
            end
         end
         F_IDLE: begin
            if (accept) begin
               g_in  = prod[18:11];
               pa_in = a_ff;
               pf_in = '{
                  add_band:  ok && in_band,
                  add_tail:  ok && in_tail,
                  also_b:    ok && in_last_col && (lc_ff != a_ff),
                  emit_band: ok && done && band_row_end,
                  emit_tail: ok && done && !band_row_end && tail_row_end,
                  newline:   ok && x_last && (band_row_end || tail_row_end),
                  nl_last:   tail_row_end
               };
               if (ok) begin
                  state_in = F_RD_A;
               end
               // advance raster position
               if (x_last) begin
                  x_in  = '0;
                  xo_in = '0;
                  a_in  = '0;
                  if (y_last) begin
                     y_in  = '0;
                     yo_in = '0;
                     ty_in = '0;
                  end else begin
                     y_in = y_ff + 1'b1;
                     if (yo_end) begin
                        yo_in = '0;
                        ty_in = ty_ff + 1'b1;
                     end else begin
                        yo_in = yo_ff + 1'b1;
                     end
                  end
               end else begin
                  x_in = x_ff + 1'b1;
                  if (xo_end) begin
                     xo_in = '0;
                     a_in  = a_ff + 1'b1;
                  end else begin
                     xo_in = xo_ff + 1'b1;
                  end
               end
            end
         end
         F_RD_A: begin
            rd_en    = 1'b1;
            rd_addr  = pa_ff;
            state_in = F_WR_A;
         end
         F_WR_A: begin
            wr_addr = pa_ff;
            band_we = pf_ff.add_band;
            tail_we = pf_ff.add_tail;
            band_wd = pf_ff.emit_band ? '0 : nb;
            tail_wd = pf_ff.emit_tail ? '0 : nt;
            if (pf_ff.emit_band || pf_ff.emit_tail) begin
               q_push = 1'b1;
               q_data = '{is_nl: 1'b0, sum: pf_ff.emit_band ? nb : nt,
                          run_last: !pf_ff.newline, frame_last: 1'b0};
            end
            priority if (pf_ff.newline) begin
               state_in = F_NL;
            end else if (pf_ff.also_b) begin
               state_in = F_RD_B;
            end else begin
               state_in = F_IDLE;
            end
         end
         F_RD_B: begin
            rd_en    = 1'b1;
            rd_addr  = lc_ff;
            state_in = F_WR_B;
         end
         F_WR_B: begin
            wr_addr  = lc_ff;
            band_we  = pf_ff.add_band;
            tail_we  = pf_ff.add_tail;
            state_in = F_IDLE;
         end
         F_NL: begin
            q_push   = 1'b1;
            q_data   = '{is_nl: 1'b1, sum: '0, run_last: 1'b1,
                         frame_last: pf_ff.nl_last};
            state_in = F_IDLE;
         end
         default: begin
            state_in = F_INIT;
         end
      endcase

      if (restart) begin
         state_in = F_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      clr_ff  <= clr_in;
      lc_ff   <= lc_in;
      lr_ff   <= lr_in;
      wrem_ff <= wrem_in;
      hrem_ff <= hrem_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      xo_ff   <= xo_in;
      yo_ff   <= yo_in;
      a_ff    <= a_in;
      ty_ff   <= ty_in;
      pa_ff   <= pa_in;
      g_ff    <= g_in;
      pf_ff   <= pf_in;
   end

   always_ff @(posedge clock) begin
      if (band_we) begin
         band_sums_ff[wr_addr] <= band_wd;
      end
      if (tail_we) begin
         tail_sums_ff[wr_addr] <= tail_wd;
      end
      if (rd_en) begin
         rd_band_ff <= band_sums_ff[rd_addr];
         rd_tail_ff <= tail_sums_ff[rd_addr];
      end
   end
endmodule

// File: src/bamap_back.sv
// ----------------------------------------------------------------------------
// bamap_back
// Tile mean by shift-subtract division, symbol lookup, result register.
// ----------------------------------------------------------------------------
module bamap_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_nonempty,
   input  bamap_pkg::item_type   q_data,
   output logic                  q_pop,
   input  logic [12:0]           area,
   input  logic [3:0]            symbol_count,
   input  logic [63:0]           symbol_table,
   output logic                  empty,
   input  logic                  pop,
   output logic [7:0]            symbol,
   output logic                  run_last,
   output logic                  frame_last
);
   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_DIV  = 3'b010,
      B_OUT  = 3'b100
   } back_state_type;

   localparam int unsigned SW = bamap_pkg::SUM_W;

   back_state_type state_ff, state_in;
   logic [SW-1:0] rem_ff, rem_in;
   logic [7:0]    quo_ff, quo_in;
   logic [2:0]    bit_ff, bit_in;
   logic          nl_ff, nl_in, rl_ff, rl_in, fl_ff, fl_in;
   logic          valid_ff, valid_in;
   logic [7:0]    sym_ff, sym_in;
   logic          orl_ff, orl_in, ofl_ff, ofl_in;
   logic [SW:0]   trial;
   logic          load;

   assign trial = (SW+1)'(area) << bit_ff;
   assign load  = (state_ff == B_OUT) && (!valid_ff || pop);

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      bit_in   = bit_ff;
      nl_in    = nl_ff;
      rl_in    = rl_ff;
      fl_in    = fl_ff;
      q_pop    = 1'b0;
      valid_in = valid_ff && !pop;
      sym_in   = sym_ff;
      orl_in   = orl_ff;
      ofl_in   = ofl_ff;

      unique case (state_ff)
         B_IDLE: begin
            if (q_nonempty) begin
               q_pop    = 1'b1;
               rem_in   = q_data.sum;
               quo_in   = '0;
               bit_in   = 3'd7;
               nl_in    = q_data.is_nl;
               rl_in    = q_data.run_last;
               fl_in    = q_data.frame_last;
               state_in = q_data.is_nl ? B_OUT : B_DIV;
            end
         end
         B_DIV: begin
            // one quotient bit a cycle, mean never exceeds eight bits
            if ({1'b0, rem_ff} >= trial) begin
               rem_in         = SW'({1'b0, rem_ff} - trial);
               quo_in[bit_ff] = 1'b1;
            end
            bit_in = bit_ff - 3'd1;
            if (bit_ff == 3'd0) begin
               state_in = B_OUT;
            end
         end
         B_OUT: begin
            if (load) begin
               valid_in = 1'b1;
               sym_in   = nl_ff ? bamap_pkg::NEWLINE
                                : bamap_pkg::pick_symbol(quo_ff, symbol_count, symbol_table);
               orl_in   = rl_ff;
               ofl_in   = fl_ff;
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      bit_ff <= bit_in;
      nl_ff  <= nl_in;
      rl_ff  <= rl_in;
      fl_ff  <= fl_in;
      sym_ff <= sym_in;
      orl_ff <= orl_in;
      ofl_ff <= ofl_in;
   end

   assign empty      = !valid_ff;
   assign symbol     = sym_ff;
   assign run_last   = orl_ff;
   assign frame_last = ofl_ff;
endmodule
